// File: design/avoc_pkg.sv
// Package for the audio voice allocator: request and result structs, action and
// register codes, controller types and shared widths. No dependencies.
package avoc_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CH_W         = $clog2(NUM_CHANNELS);

    localparam int LEN_W   = 17;
    localparam int RATE_W  = 15;
    localparam int FPS_W   = 8;
    localparam int PROD_W  = LEN_W + FPS_W;
    localparam int NUM_W   = PROD_W + 1;
    localparam int STEP_W  = $clog2(NUM_W);
    localparam int TICKS_W = 15;
    localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SFX_MASK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAN_STEAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_FREE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FPS        = 3'd4;

    localparam logic [NUM_CHANNELS-1:0] SFX_MASK_RST   = '1;
    localparam logic [NUM_CHANNELS-1:0] MUSIC_MASK_RST = '1;
    localparam logic [FPS_W-1:0]        FPS_RST        = 8'd50;

    localparam logic [2:0] ACT_PLAY_SFX   = 3'd0;
    localparam logic [2:0] ACT_TICK       = 3'd1;
    localparam logic [2:0] ACT_STOP_ALL   = 3'd2;
    localparam logic [2:0] ACT_FREE_SFX   = 3'd3;
    localparam logic [2:0] ACT_PLAY_MUSIC = 3'd4;
    localparam logic [2:0] ACT_STOP_MUSIC = 3'd5;
    localparam logic [2:0] ACT_PAUSE      = 3'd6;
    localparam logic [2:0] ACT_RESUME     = 3'd7;

    typedef struct packed {
        logic [2:0]        action;
        logic [7:0]        handle_id;
        logic [7:0]        priority_req;
        logic [LEN_W-1:0]  snd_len;
        logic [RATE_W-1:0] snd_rate;
        logic              loop_music;
    } t_in_req;

    typedef struct packed {
        logic                    granted;
        logic [1:0]              granted_channel;
        logic [NUM_CHANNELS-1:0] active_mask;
        logic [2:0]              active_count;
        logic [NUM_CHANNELS-1:0] music_mask;
        logic                    music_running;
        logic                    music_paused;
        logic                    music_looping;
    } t_out_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic take;
        logic load;
        logic mul;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_play;
        logic out_stall;
    } t_sts;

    // Channel that lies ofs places after base, wrapping at the channel count.
    function automatic logic [CH_W-1:0] rot_ch(logic [CH_W-1:0] base, int unsigned ofs);
        logic [CH_W:0] s;
        s = {1'b0, base} + (CH_W+1)'(ofs);
        if (s >= (CH_W+1)'(NUM_CHANNELS)) begin
            s = s - (CH_W+1)'(NUM_CHANNELS);
        end
        return s[CH_W-1:0];
    endfunction

endpackage

// File: design/avoc_ctrl.sv
// Controller state machine of the audio voice allocator.
// Depends on avoc_pkg for the state, command and status types.
module avoc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  avoc_pkg::t_sts  i_sts,
    output avoc_pkg::t_cmd  o_cmd
);

    avoc_pkg::t_state r_state, n_state;
    logic [avoc_pkg::STEP_W-1:0] r_step, n_step;
    logic w_last;

    assign w_last = (r_step == avoc_pkg::STEP_W'(avoc_pkg::NUM_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= avoc_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state and step count.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            avoc_pkg::ST_IDLE: begin
                if (i_sts.in_valid) begin
                    n_state = i_sts.in_play ? avoc_pkg::ST_MUL : avoc_pkg::ST_COMMIT;
                end
            end
            avoc_pkg::ST_MUL: begin
                n_step  = '0;
                n_state = avoc_pkg::ST_DIV;
            end
            avoc_pkg::ST_DIV: begin
                n_step = r_step + 1'b1;
                if (w_last) begin
                    n_state = avoc_pkg::ST_COMMIT;
                end
            end
            avoc_pkg::ST_COMMIT: begin
                if (!i_sts.out_stall) begin
                    n_state = avoc_pkg::ST_IDLE;
                end
            end
            default: n_state = avoc_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            avoc_pkg::ST_IDLE: begin
                o_cmd.take = 1'b1;
                o_cmd.load = i_sts.in_valid;
            end
            avoc_pkg::ST_MUL:    o_cmd.mul      = 1'b1;
            avoc_pkg::ST_DIV:    o_cmd.div_step = 1'b1;
            avoc_pkg::ST_COMMIT: o_cmd.commit   = !i_sts.out_stall;
            default:             o_cmd = '0;
        endcase
    end

endmodule

// File: design/avoc_ticks.sv
// Tick count unit: multiplies length by frame rate, then divides by the sample
// rate one quotient bit per cycle. Depends on avoc_pkg for widths and commands.
module avoc_ticks (
    input  logic                          i_clk,
    input  avoc_pkg::t_cmd                i_cmd,
    input  logic [avoc_pkg::LEN_W-1:0]    i_len,
    input  logic [avoc_pkg::RATE_W-1:0]   i_rate,
    input  logic [avoc_pkg::FPS_W-1:0]    i_fps,
    output logic [avoc_pkg::TICKS_W-1:0]  o_ticks
);

    localparam int NW = avoc_pkg::NUM_W;
    localparam int RW = avoc_pkg::RATE_W;

    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_div;
    logic          r_trivial;

    logic [avoc_pkg::PROD_W-1:0] w_prod;
    logic [RW:0]                 w_rem_sh;
    logic                        w_fit;

    assign w_prod   = avoc_pkg::PROD_W'(i_len) * avoc_pkg::PROD_W'(i_fps);
    assign w_rem_sh = {r_rem, r_num[NW-1]};
    assign w_fit    = (w_rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            // The sum is the rounded-up numerator; zero rate is caught below.
            r_num     <= {1'b0, w_prod} + NW'(i_rate) - NW'(1);
            r_quo     <= '0;
            r_rem     <= '0;
            r_div     <= i_rate;
            r_trivial <= (i_rate == '0) || (i_fps == '0);
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_quo <= {r_quo[NW-2:0], w_fit};
            r_rem <= w_fit ? RW'(w_rem_sh - {1'b0, r_div}) : w_rem_sh[RW-1:0];
        end
    end

    always_comb begin
        if (r_trivial || (r_quo == '0)) begin
            o_ticks = avoc_pkg::TICKS_W'(1);
        end else if (r_quo[NW-1:avoc_pkg::TICKS_W] != '0) begin
            o_ticks = avoc_pkg::TICKS_MAX;
        end else begin
            o_ticks = r_quo[avoc_pkg::TICKS_W-1:0];
        end
    end

endmodule

// File: design/avoc_voices.sv
// Voice and music state of the audio voice allocator, its configuration
// registers and the result register. Depends on avoc_pkg.
module avoc_voices (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  avoc_pkg::t_cmd                  i_cmd,
    input  avoc_pkg::t_in_req               i_req,
    input  logic [avoc_pkg::TICKS_W-1:0]    i_ticks,
    input  logic                            i_cfg_we,
    input  logic [avoc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [avoc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_out_ready,
    output logic [avoc_pkg::FPS_W-1:0]      o_fps,
    output logic                            o_out_valid,
    output avoc_pkg::t_out_res              o_out_data
);

    localparam int NC = avoc_pkg::NUM_CHANNELS;
    localparam int CW = avoc_pkg::CH_W;
    localparam int TW = avoc_pkg::TICKS_W;

    // Configuration.
    logic [NC-1:0]              r_sfx_mask;
    logic [NC-1:0]              r_music_mask;
    logic                       r_can_steal;
    logic                       r_use_free;
    logic [avoc_pkg::FPS_W-1:0] r_fps;

    // Voice state.
    logic [NC-1:0] r_active, n_active;
    logic [7:0]    r_handle [NC];
    logic [7:0]    n_handle [NC];
    logic [7:0]    r_prio   [NC];
    logic [7:0]    n_prio   [NC];
    logic [TW-1:0] r_ticks  [NC];
    logic [TW-1:0] n_ticks  [NC];
    logic [CW-1:0] r_ptr, n_ptr;

    // Music state.
    logic [NC-1:0] r_claimed, n_claimed;
    logic [NC-1:0] r_stolen, n_stolen;
    logic          r_music_on, n_music_on;
    logic          r_music_held, n_music_held;
    logic          r_music_loaded, n_music_loaded;
    logic          r_music_loop, n_music_loop;

    logic               r_out_valid;
    avoc_pkg::t_out_res r_out;
    avoc_pkg::t_out_res n_out;

    logic [NC-1:0] w_allowed;
    logic [NC-1:0] w_prio_ok;
    logic [NC-1:0] w_music_new;
    logic          w_hit;
    logic [CW-1:0] w_ch;
    logic [CW-1:0] w_cand;

    assign o_fps       = r_fps;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Channel pick: first idle allowed channel from the pointer, else the
    // first allowed channel whose stored priority the request meets.
    always_comb begin
        w_allowed = r_sfx_mask | ((r_can_steal && r_music_on) ? r_claimed : '0);
        for (int c = 0; c < NC; c++) begin
            w_prio_ok[c] = (i_req.priority_req >= r_prio[c]);
        end
        w_hit  = 1'b0;
        w_ch   = '0;
        w_cand = '0;
        for (int i = 0; i < NC; i++) begin
            w_cand = avoc_pkg::rot_ch(r_ptr, i);
            if (!w_hit && w_allowed[w_cand] && !r_active[w_cand]) begin
                w_hit = 1'b1;
                w_ch  = w_cand;
            end
        end
        for (int i = 0; i < NC; i++) begin
            w_cand = avoc_pkg::rot_ch(r_ptr, i);
            if (!w_hit && w_allowed[w_cand] && w_prio_ok[w_cand]) begin
                w_hit = 1'b1;
                w_ch  = w_cand;
            end
        end
    end

    assign w_music_new = r_music_mask | (r_use_free ? (r_sfx_mask & ~r_active) : '0);

    // State after the latched request.
    always_comb begin
        n_active       = r_active;
        n_handle       = r_handle;
        n_prio         = r_prio;
        n_ticks        = r_ticks;
        n_ptr          = r_ptr;
        n_claimed      = r_claimed;
        n_stolen       = r_stolen;
        n_music_on     = r_music_on;
        n_music_held   = r_music_held;
        n_music_loaded = r_music_loaded;
        n_music_loop   = r_music_loop;
        n_out          = '0;
        case (i_req.action)
            avoc_pkg::ACT_PLAY_SFX: begin
                if (w_hit) begin
                    if (r_music_on && r_claimed[w_ch]) begin
                        n_stolen[w_ch] = 1'b1;
                    end
                    n_active[w_ch]        = 1'b1;
                    n_handle[w_ch]        = i_req.handle_id;
                    n_prio[w_ch]          = i_req.priority_req;
                    n_ticks[w_ch]         = i_ticks;
                    n_ptr                 = avoc_pkg::rot_ch(w_ch, 1);
                    n_out.granted         = 1'b1;
                    n_out.granted_channel = 2'(w_ch);
                end
            end
            avoc_pkg::ACT_TICK: begin
                for (int c = 0; c < NC; c++) begin
                    if (r_active[c]) begin
                        if (r_ticks[c] <= TW'(1)) begin
                            n_active[c] = 1'b0;
                            n_stolen[c] = 1'b0;
                            n_handle[c] = '0;
                            n_prio[c]   = '0;
                            n_ticks[c]  = '0;
                        end else begin
                            n_ticks[c] = r_ticks[c] - TW'(1);
                        end
                    end
                end
            end
            avoc_pkg::ACT_STOP_ALL: begin
                for (int c = 0; c < NC; c++) begin
                    n_active[c] = 1'b0;
                    n_stolen[c] = 1'b0;
                    n_handle[c] = '0;
                    n_prio[c]   = '0;
                    n_ticks[c]  = '0;
                end
            end
            avoc_pkg::ACT_FREE_SFX: begin
                for (int c = 0; c < NC; c++) begin
                    if (r_active[c] && (r_handle[c] == i_req.handle_id)) begin
                        n_active[c] = 1'b0;
                        n_stolen[c] = 1'b0;
                        n_handle[c] = '0;
                        n_prio[c]   = '0;
                        n_ticks[c]  = '0;
                    end
                end
            end
            avoc_pkg::ACT_PLAY_MUSIC: begin
                n_claimed      = w_music_new;
                n_music_loaded = 1'b1;
                n_stolen       = '0;
                n_music_on     = (w_music_new != '0);
                n_music_held   = 1'b0;
                n_music_loop   = i_req.loop_music;
            end
            avoc_pkg::ACT_STOP_MUSIC: begin
                n_music_loaded = 1'b0;
                n_claimed      = '0;
                n_stolen       = '0;
                n_music_on     = 1'b0;
                n_music_held   = 1'b0;
                n_music_loop   = 1'b0;
            end
            avoc_pkg::ACT_PAUSE: begin
                if (r_music_on) begin
                    n_music_held = 1'b1;
                end
            end
            avoc_pkg::ACT_RESUME: begin
                if (r_music_loaded && (r_claimed != '0)) begin
                    n_music_on   = 1'b1;
                    n_music_held = 1'b0;
                end
            end
            default: n_music_on = r_music_on;
        endcase
        n_out.active_mask   = n_active;
        n_out.active_count  = 3'($countones(n_active));
        n_out.music_mask    = n_music_on ? (n_claimed & ~n_stolen) : '0;
        n_out.music_running = n_music_on && !n_music_held;
        n_out.music_paused  = n_music_held;
        n_out.music_looping = n_music_loop;
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sfx_mask     <= avoc_pkg::SFX_MASK_RST;
            r_music_mask   <= avoc_pkg::MUSIC_MASK_RST;
            r_can_steal    <= 1'b1;
            r_use_free     <= 1'b1;
            r_fps          <= avoc_pkg::FPS_RST;
            r_active       <= '0;
            r_ptr          <= '0;
            r_claimed      <= '0;
            r_stolen       <= '0;
            r_music_on     <= 1'b0;
            r_music_held   <= 1'b0;
            r_music_loaded <= 1'b0;
            r_music_loop   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    avoc_pkg::CFG_SFX_MASK:   r_sfx_mask   <= i_cfg_data[NC-1:0];
                    avoc_pkg::CFG_MUSIC_MASK: r_music_mask <= i_cfg_data[NC-1:0];
                    avoc_pkg::CFG_CAN_STEAL:  r_can_steal  <= i_cfg_data[0];
                    avoc_pkg::CFG_USE_FREE:   r_use_free   <= i_cfg_data[0];
                    avoc_pkg::CFG_FPS:        r_fps        <= i_cfg_data;
                    default:                  r_fps        <= r_fps;
                endcase
            end
            if (i_cmd.commit) begin
                r_active       <= n_active;
                r_ptr          <= n_ptr;
                r_claimed      <= n_claimed;
                r_stolen       <= n_stolen;
                r_music_on     <= n_music_on;
                r_music_held   <= n_music_held;
                r_music_loaded <= n_music_loaded;
                r_music_loop   <= n_music_loop;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-voice payload; only read while the voice is active.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_handle <= n_handle;
            r_prio   <= n_prio;
            r_ticks  <= n_ticks;
            r_out    <= n_out;
        end
    end

endmodule

// File: design/audio_voice_allocator.sv
// Top level of the audio voice allocator: request register, controller, tick
// unit and voice state. Depends on avoc_pkg, avoc_ctrl, avoc_ticks, avoc_voices.
//
// Usage: one request enters on the input channel (i_in_valid/o_in_ready,
// payload i_in_data) and produces exactly one result on the output channel
// (o_out_valid/i_out_ready, payload o_out_data). The result reports the grant
// of a play request and the effect and music status after the request.
// Registers are written on the configuration channel (i_cfg_valid/o_cfg_ready,
// i_cfg_index, i_cfg_data); it is ready whenever reset is released and should
// be used only while no request is in flight. Indexes past the list are ignored.
// A play-sound request passes through a multiply step, 26 restoring division
// steps that form the tick count one quotient bit each, and a commit step; any
// other request goes from acceptance straight to its commit step. A new request
// is taken only once the previous one has committed, so the division loop sets
// the pace of play requests.
// A request is accepted while the previous result still waits in the output
// register; if the receiver stalls, the next request holds in its commit
// step until the output register frees up, so nothing is lost.
// Reset (synchronous, active low) frees all voices, stops music, clears the
// rotating pointer and loads the register defaults; both ready outputs are low.
module audio_voice_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  avoc_pkg::t_in_req               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output avoc_pkg::t_out_res              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [avoc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [avoc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    avoc_pkg::t_cmd    w_cmd;
    avoc_pkg::t_sts    w_sts;
    avoc_pkg::t_in_req r_req;

    logic [avoc_pkg::TICKS_W-1:0] w_ticks;
    logic [avoc_pkg::FPS_W-1:0]   w_fps;

    // The configuration port never stalls once reset is released. Neither
    // channel takes a request while reset is held.
    assign o_cfg_ready = i_rst_n;
    assign o_in_ready  = w_cmd.take && i_rst_n;

    // Status for the controller: a request waiting, whether it needs the
    // tick division, and whether the output register is still occupied.
    assign w_sts.in_valid  = i_in_valid;
    assign w_sts.in_play   = (i_in_data.action == avoc_pkg::ACT_PLAY_SFX);
    assign w_sts.out_stall = o_out_valid && !i_out_ready;

    // The accepted request is held here for the whole of its processing.
    always_ff @(posedge i_clk) begin
        if (w_cmd.load) begin
            r_req <= i_in_data;
        end
    end

    avoc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    avoc_ticks u_ticks (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_len   (r_req.snd_len),
        .i_rate  (r_req.snd_rate),
        .i_fps   (w_fps),
        .o_ticks (w_ticks)
    );

    avoc_voices u_voices (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req       (r_req),
        .i_ticks     (w_ticks),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_fps       (w_fps),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTH
    // An accepted request blocks the input until it has been committed.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a request was accepted");

    // A commit never overwrites a result that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> !(o_out_valid && !i_out_ready))
        else $error("commit while output register is stalled");

    // Paused music is never reported as running.
    a_music_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.music_running && o_out_data.music_paused))
        else $error("music both running and paused");

    // The active count follows the active mask.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.active_count == 3'($countones(o_out_data.active_mask))))
        else $error("active count disagrees with active mask");
`endif

endmodule

// File: dv/tb.sv
// Self-checking testbench for audio_voice_allocator: drives requests, register
// writes and output stalls, and checks every result.
// Depends on avoc_pkg and the design.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CHANNELS = avoc_pkg::NUM_CHANNELS;
    localparam int CH_W         = avoc_pkg::CH_W;
    localparam int LEN_W        = avoc_pkg::LEN_W;
    localparam int RATE_W       = avoc_pkg::RATE_W;
    localparam int FPS_W        = avoc_pkg::FPS_W;
    localparam int TICKS_W      = avoc_pkg::TICKS_W;
    localparam int CFG_IDX_W    = avoc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = avoc_pkg::CFG_DATA_W;

    // The watchdog ends the run after this many cycles without any handshake.
    // This leaves a wide margin over a play request, even for long receiver stalls
    // stacked on sender gaps.
    localparam int STALL_LIMIT = 4000;
    // Cycles to wait after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 40;
    // First register index past the end of the list; writes there are ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_PAST_END = CFG_IDX_W'(avoc_pkg::CFG_FPS + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX  = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    avoc_pkg::t_in_req     i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    avoc_pkg::t_out_res    o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    audio_voice_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Requests waiting to be offered, and the status each accepted request
    // should produce, oldest first.
    avoc_pkg::t_in_req  req_backlog[$];
    avoc_pkg::t_out_res status_due[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;

    // Shadow copy of the register file, starting at the reset defaults.
    logic [NUM_CHANNELS-1:0] cfg_sfx_mask = avoc_pkg::SFX_MASK_RST;
    logic [NUM_CHANNELS-1:0] cfg_mus_mask = avoc_pkg::MUSIC_MASK_RST;
    logic                    cfg_steal    = 1'b1;
    logic                    cfg_use_free = 1'b1;
    logic [FPS_W-1:0]        cfg_fps      = avoc_pkg::FPS_RST;

    // Shadow copy of the voice and music state.
    logic [7:0]              v_hnd  [NUM_CHANNELS];
    logic [7:0]              v_prio [NUM_CHANNELS];
    logic [TICKS_W-1:0]      v_left [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] v_busy    = '0;
    logic [CH_W-1:0]         rr_ptr    = '0;
    logic [NUM_CHANNELS-1:0] mus_claim = '0;
    logic [NUM_CHANNELS-1:0] mus_steal = '0;
    logic                    mus_on    = 1'b0;
    logic                    mus_hold  = 1'b0;
    logic                    mus_load  = 1'b0;
    logic [7:0]              mus_id    = '0;
    logic                    mus_loop  = 1'b0;

    // Freeing a voice also drops its stolen mark on the music side.
    function automatic void release_voice(int ch);
        mus_steal[ch] = 1'b0;
        v_hnd[ch]     = '0;
        v_busy[ch]    = 1'b0;
        v_prio[ch]    = '0;
        v_left[ch]    = '0;
    endfunction

    // Applies one request to the shadow state and returns the status the
    // block must report for it.
    function automatic avoc_pkg::t_out_res voice_outcome(avoc_pkg::t_in_req r);
        avoc_pkg::t_out_res      res;
        logic [NUM_CHANNELS-1:0] allowed;
        int                      ch;
        int                      pick;
        int unsigned             q;
        res = '0;
        case (r.action)
            avoc_pkg::ACT_PLAY_SFX: begin
                allowed = cfg_sfx_mask;
                if (cfg_steal && mus_on) begin
                    allowed |= mus_claim;
                end
                pick = -1;
                if (allowed != '0) begin
                    // An idle channel wins first, scanning from the pointer.
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        ch = (int'(rr_ptr) + i) % NUM_CHANNELS;
                        if (pick < 0 && allowed[ch] && !v_busy[ch]) begin
                            pick = ch;
                        end
                    end
                    // Otherwise the first channel whose priority the request meets.
                    if (pick < 0) begin
                        for (int i = 0; i < NUM_CHANNELS; i++) begin
                            ch = (int'(rr_ptr) + i) % NUM_CHANNELS;
                            if (pick < 0 && allowed[ch] && r.priority_req >= v_prio[ch]) begin
                                pick = ch;
                            end
                        end
                    end
                end
                if (pick >= 0) begin
                    rr_ptr = CH_W'((pick + 1) % NUM_CHANNELS);
                    if (mus_on && mus_claim[pick]) begin
                        mus_steal[pick] = 1'b1;
                    end
                    // Length in ticks, rounded up and clamped; a zero rate or
                    // a zero tick rate gives a single tick.
                    if (r.snd_rate == '0 || cfg_fps == '0) begin
                        q = 1;
                    end else begin
                        q = (32'(r.snd_len) * 32'(cfg_fps) + 32'(r.snd_rate) - 32'd1)
                            / 32'(r.snd_rate);
                        if (q < 1) begin
                            q = 1;
                        end
                        if (q > 32'(avoc_pkg::TICKS_MAX)) begin
                            q = 32'(avoc_pkg::TICKS_MAX);
                        end
                    end
                    v_hnd[pick]  = r.handle_id;
                    v_busy[pick] = 1'b1;
                    v_prio[pick] = r.priority_req;
                    v_left[pick] = TICKS_W'(q);
                    res.granted         = 1'b1;
                    res.granted_channel = 2'(pick);
                end
            end
            avoc_pkg::ACT_TICK: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (v_busy[i]) begin
                        if (v_left[i] <= 1) begin
                            release_voice(i);
                        end else begin
                            v_left[i] = v_left[i] - 1'b1;
                        end
                    end
                end
            end
            avoc_pkg::ACT_STOP_ALL: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    release_voice(i);
                end
            end
            avoc_pkg::ACT_FREE_SFX: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (v_busy[i] && v_hnd[i] == r.handle_id) begin
                        release_voice(i);
                    end
                end
            end
            avoc_pkg::ACT_PLAY_MUSIC: begin
                allowed = cfg_mus_mask;
                if (cfg_use_free) begin
                    allowed |= cfg_sfx_mask & ~v_busy;
                end
                mus_claim = allowed;
                mus_load  = 1'b1;
                mus_id    = r.handle_id;
                mus_steal = '0;
                mus_on    = (allowed != '0);
                mus_hold  = 1'b0;
                mus_loop  = r.loop_music;
            end
            avoc_pkg::ACT_STOP_MUSIC: begin
                mus_load  = 1'b0;
                mus_id    = '0;
                mus_claim = '0;
                mus_steal = '0;
                mus_on    = 1'b0;
                mus_hold  = 1'b0;
                mus_loop  = 1'b0;
            end
            avoc_pkg::ACT_PAUSE: begin
                if (mus_on) begin
                    mus_hold = 1'b1;
                end
            end
            avoc_pkg::ACT_RESUME: begin
                if (mus_load && mus_claim != '0) begin
                    mus_on   = 1'b1;
                    mus_hold = 1'b0;
                end
            end
            default: begin
            end
        endcase
        res.active_mask   = v_busy;
        res.active_count  = 3'($countones(v_busy));
        res.music_mask    = mus_on ? (mus_claim & ~mus_steal) : '0;
        res.music_running = mus_on && !mus_hold;
        res.music_paused  = mus_hold;
        res.music_looping = mus_loop;
        return res;
    endfunction

    function automatic void queue_req(logic [2:0] act, logic [7:0] hnd, logic [7:0] prio,
                                      logic [LEN_W-1:0] len, logic [RATE_W-1:0] rate,
                                      logic lp);
        avoc_pkg::t_in_req r;
        r.action       = act;
        r.handle_id    = hnd;
        r.priority_req = prio;
        r.snd_len      = len;
        r.snd_rate     = rate;
        r.loop_music   = lp;
        req_backlog.push_back(r);
    endfunction

    // Request driver. A held request stays on the bus until it is taken; a new
    // one is offered only when the bus is free or the current one is taken in
    // this cycle, so valid never drops between back-to-back requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                status_due.push_back(voice_outcome(i_in_data));
            end
            if (!i_in_valid || o_in_ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_data  <= req_backlog.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls. Each result is checked field by
    // field against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        avoc_pkg::t_out_res want;
        logic               off;
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (status_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("tb: result with no request outstanding: %h", o_out_data);
                end
            end else begin
                want = status_due.pop_front();
                off  = (o_out_data.granted         !== want.granted)
                    || (o_out_data.granted_channel !== want.granted_channel)
                    || (o_out_data.active_mask     !== want.active_mask)
                    || (o_out_data.active_count    !== want.active_count)
                    || (o_out_data.music_mask      !== want.music_mask)
                    || (o_out_data.music_running   !== want.music_running)
                    || (o_out_data.music_paused    !== want.music_paused)
                    || (o_out_data.music_looping   !== want.music_looping);
                if (off) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("tb: mismatch at %0t", $realtime);
                        $display("tb:   want g=%b ch=%0d act=%b n=%0d mus=%b run=%b pau=%b lp=%b",
                                 want.granted, want.granted_channel,
                                 want.active_mask, want.active_count, want.music_mask,
                                 want.music_running, want.music_paused, want.music_looping);
                        $display("tb:   got  g=%b ch=%0d act=%b n=%0d mus=%b run=%b pau=%b lp=%b",
                                 o_out_data.granted, o_out_data.granted_channel,
                                 o_out_data.active_mask, o_out_data.active_count,
                                 o_out_data.music_mask, o_out_data.music_running,
                                 o_out_data.music_paused, o_out_data.music_looping);
                    end
                end
            end
        end
    end

    // Watchdog: any handshake on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: watchdog expired with %0d results outstanding", status_due.size());
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Waits until every queued request has been offered, taken and answered.
    task automatic wait_drained();
        while (req_backlog.size() != 0 || i_in_valid || status_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One register write; the shadow copy follows at the handshake.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            avoc_pkg::CFG_SFX_MASK:   cfg_sfx_mask = val[NUM_CHANNELS-1:0];
            avoc_pkg::CFG_MUSIC_MASK: cfg_mus_mask = val[NUM_CHANNELS-1:0];
            avoc_pkg::CFG_CAN_STEAL:  cfg_steal    = val[0];
            avoc_pkg::CFG_USE_FREE:   cfg_use_free = val[0];
            avoc_pkg::CFG_FPS:        cfg_fps      = val;
            default: begin
            end
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // One phase: let the block go idle, load a register setting (unused data
    // bits are filled with noise), then queue a music start and resume
    // followed by random traffic.
    task automatic run_phase(input logic [3:0] sfx, input logic [3:0] mus, input logic steal,
                             input logic use_free, input logic [7:0] fps, input int n_rand);
        avoc_pkg::t_in_req r;
        int                k;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(avoc_pkg::CFG_SFX_MASK,   {4'($urandom_range(15)), sfx});
        write_reg(avoc_pkg::CFG_MUSIC_MASK, {4'($urandom_range(15)), mus});
        write_reg(avoc_pkg::CFG_CAN_STEAL,  {7'($urandom_range(127)), steal});
        write_reg(avoc_pkg::CFG_USE_FREE,   {7'($urandom_range(127)), use_free});
        write_reg(avoc_pkg::CFG_FPS,        fps);
        queue_req(avoc_pkg::ACT_PLAY_MUSIC, 8'($urandom_range(255)), 8'd0, LEN_W'(1),
                  RATE_W'(1000), 1'($urandom_range(1)));
        queue_req(avoc_pkg::ACT_RESUME, 8'd0, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);
        for (int n = 0; n < n_rand; n++) begin
            // Handles mostly come from a small pool so that frees find their
            // voices; short sounds dominate so that ticks expire them.
            r.handle_id = ($urandom_range(99) < 80) ? 8'($urandom_range(7))
                                                    : 8'($urandom_range(255));
            k = $urandom_range(99);
            if (k < 30) begin
                r.priority_req = 8'($urandom_range(3));
            end else if (k < 40) begin
                r.priority_req = 8'hFF;
            end else begin
                r.priority_req = 8'($urandom_range(255));
            end
            k = $urandom_range(99);
            if (k < 60) begin
                r.snd_len = LEN_W'($urandom_range(800, 1));
            end else if (k < 85) begin
                r.snd_len = LEN_W'($urandom_range(131070, 1));
            end else begin
                r.snd_len = LEN_W'($urandom_range(131071, 0));
            end
            k = $urandom_range(99);
            if (k < 85) begin
                r.snd_rate = RATE_W'($urandom_range(30000, 1000));
            end else if (k < 95) begin
                r.snd_rate = RATE_W'($urandom_range(32767, 0));
            end else begin
                r.snd_rate = RATE_W'($urandom_range(999, 0));
            end
            r.loop_music = 1'($urandom_range(1));
            k = $urandom_range(99);
            if (k < 40) begin
                r.action = avoc_pkg::ACT_PLAY_SFX;
            end else if (k < 65) begin
                r.action = avoc_pkg::ACT_TICK;
            end else if (k < 73) begin
                r.action = avoc_pkg::ACT_FREE_SFX;
            end else if (k < 79) begin
                r.action = avoc_pkg::ACT_PLAY_MUSIC;
            end else if (k < 83) begin
                r.action = avoc_pkg::ACT_STOP_MUSIC;
            end else if (k < 89) begin
                r.action = avoc_pkg::ACT_PAUSE;
            end else if (k < 95) begin
                r.action = avoc_pkg::ACT_RESUME;
            end else begin
                r.action = avoc_pkg::ACT_STOP_ALL;
            end
            req_backlog.push_back(r);
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            release_voice(i);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles 35 percent, receiver 49 percent for the first phases.
        send_idle_pct = 35;
        recv_idle_pct = 49;

        // Directed requests under the reset register values. Music starts on
        // all channels, pauses and resumes, then effects fill every channel,
        // with a zero rate, a clamped length, and two priority takeovers
        // onto busy channels followed by a request that no channel admits.
        queue_req(avoc_pkg::ACT_PLAY_MUSIC, 8'hFF, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b1);
        queue_req(avoc_pkg::ACT_PAUSE, 8'd0, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);
        queue_req(avoc_pkg::ACT_PAUSE, 8'd0, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);
        queue_req(avoc_pkg::ACT_RESUME, 8'd0, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);
        queue_req(avoc_pkg::ACT_PLAY_SFX, 8'd1, 8'd0, LEN_W'(1), RATE_W'(30000), 1'b0);
        queue_req(avoc_pkg::ACT_PLAY_SFX, 8'd2, 8'hFF, LEN_W'(131070), RATE_W'(1000), 1'b0);
        queue_req(avoc_pkg::ACT_PLAY_SFX, 8'd3, 8'd7, LEN_W'(500), RATE_W'(0), 1'b0);
        queue_req(avoc_pkg::ACT_PLAY_SFX, 8'd3, 8'd7, LEN_W'(131071), RATE_W'(1), 1'b1);
        queue_req(avoc_pkg::ACT_PLAY_SFX, 8'd4, 8'd0, LEN_W'(100), RATE_W'(8000), 1'b0);
        queue_req(avoc_pkg::ACT_PLAY_SFX, 8'd5, 8'd6, LEN_W'(200), RATE_W'(8000), 1'b0);
        queue_req(avoc_pkg::ACT_PLAY_SFX, 8'd6, 8'd0, LEN_W'(0), RATE_W'(32767), 1'b0);
        queue_req(avoc_pkg::ACT_TICK, 8'd0, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);
        // Free by handle hits one voice; the second free matches nothing.
        queue_req(avoc_pkg::ACT_FREE_SFX, 8'd3, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);
        queue_req(avoc_pkg::ACT_FREE_SFX, 8'hEE, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);
        // Music is stopped; a pause is then ignored, and a resume finds
        // nothing loaded.
        queue_req(avoc_pkg::ACT_STOP_MUSIC, 8'd0, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);
        queue_req(avoc_pkg::ACT_PAUSE, 8'd0, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);
        queue_req(avoc_pkg::ACT_RESUME, 8'd0, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);
        queue_req(avoc_pkg::ACT_PLAY_MUSIC, 8'h10, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);
        queue_req(avoc_pkg::ACT_STOP_ALL, 8'd0, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);
        queue_req(avoc_pkg::ACT_TICK, 8'd0, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);
        queue_req(avoc_pkg::ACT_PLAY_SFX, 8'hFF, 8'hFF, LEN_W'(1), RATE_W'(16384), 1'b0);
        queue_req(avoc_pkg::ACT_PLAY_MUSIC, 8'd0, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b1);
        queue_req(avoc_pkg::ACT_PAUSE, 8'd0, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);
        // Starting music again while paused clears the pause.
        queue_req(avoc_pkg::ACT_PLAY_MUSIC, 8'd9, 8'd0, LEN_W'(1), RATE_W'(1000), 1'b0);

        // Default setting, then nothing open to effects and no music channel
        // (nothing can be granted, music loads but stays off), then the
        // lowest nonzero tick rate with stealing off.
        run_phase(4'hF, 4'hF, 1'b1, 1'b1, 8'd50, 100);
        run_phase(4'h0, 4'h0, 1'b0, 1'b0, 8'd255, 50);
        run_phase(4'hF, 4'hF, 1'b0, 1'b1, 8'd1, 110);

        send_idle_pct = 49;
        recv_idle_pct = 35;
        // Split masks and a zero tick rate, then a random setting.
        run_phase(4'h3, 4'hC, 1'b1, 1'b0, 8'd0, 110);
        run_phase(4'($urandom_range(15)), 4'($urandom_range(15)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 8'($urandom_range(255)), 110);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Indexes past the register list must leave the setting alone.
        wait_drained();
        write_reg(CFG_PAST_END, 8'($urandom_range(255)));
        write_reg(CFG_TOP_IDX,  8'($urandom_range(255)));
        run_phase(4'hF, 4'h0, 1'b1, 1'b1, 8'd50, 110);
        run_phase(4'($urandom_range(15)), 4'($urandom_range(15)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 8'($urandom_range(255, 1)), 100);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && status_due.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
